>>> src/bfpp_pkg.sv
// package: shared constants and types for the bounding box block
`default_nettype none
package bfpp_pkg;

    localparam int DIM_BITS     = 14;
    localparam int RATIO_BITS   = 12;
    localparam int RATIO_FRAC   = 8;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMG_W      = 2'd0,
        CFG_IMG_H      = 2'd1,
        CFG_ROI_ENABLE = 2'd2,
        CFG_GROW_RATIO = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_BITS-1:0]   img_w;
        logic [DIM_BITS-1:0]   img_h;
        logic                  roi_enable;
        logic [RATIO_BITS-1:0] grow_ratio;
    } t_cfg;

    localparam logic [DIM_BITS-1:0]   RST_IMG_W      = 14'd1920;
    localparam logic [DIM_BITS-1:0]   RST_IMG_H      = 14'd1080;
    localparam logic                  RST_ROI_ENABLE = 1'b0;
    localparam logic [RATIO_BITS-1:0] RST_GROW_RATIO = 12'd0;

endpackage
`default_nettype wire

>>> src/bfpp_front.sv
// front end: running min/max accumulation per frame, emits one frame record on the last item
`default_nettype none
module bfpp_front #(
    parameter int COORD_BITS = 20
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire signed [COORD_BITS-1:0] i_point_x,
    input  wire signed [COORD_BITS-1:0] i_point_y,
    input  wire                         i_point_ok,
    input  wire                         i_last_point,
    output logic                        o_rec_push,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic                        o_bad
);
    localparam logic signed [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CoordMin = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [COORD_BITS-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
    logic                         r_bad, n_bad;
    logic                         upd;
    logic                         frame_end;

    always_comb begin
        upd       = i_accept & i_point_ok;
        frame_end = i_accept & i_last_point;
        o_min_x   = (upd && (i_point_x < r_min_x)) ? i_point_x : r_min_x;
        o_min_y   = (upd && (i_point_y < r_min_y)) ? i_point_y : r_min_y;
        o_max_x   = (upd && (i_point_x > r_max_x)) ? i_point_x : r_max_x;
        o_max_y   = (upd && (i_point_y > r_max_y)) ? i_point_y : r_max_y;
        o_bad     = r_bad | (i_accept & ~i_point_ok);
        o_rec_push = frame_end;
        if (frame_end) begin
            n_min_x = CoordMax;
            n_min_y = CoordMax;
            n_max_x = CoordMin;
            n_max_y = CoordMin;
            n_bad   = 1'b0;
        end else begin
            n_min_x = o_min_x;
            n_min_y = o_min_y;
            n_max_x = o_max_x;
            n_max_y = o_max_y;
            n_bad   = o_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= CoordMax;
            r_min_y <= CoordMax;
            r_max_x <= CoordMin;
            r_max_y <= CoordMin;
            r_bad   <= 1'b0;
        end else begin
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
            r_bad   <= n_bad;
        end
    end

endmodule
`default_nettype wire

>>> src/bfpp_fifo.sv
// short queue of frame records between front and back
`default_nettype none
module bfpp_fifo #(
    parameter int WIDTH = 121
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int Depth  = 4;
    localparam int PtrW   = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);

    logic [WIDTH-1:0]  r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CountW-1:0] r_count;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (r_count == CountW'(Depth));
        o_empty = (r_count == '0);
        do_push = i_push & ~o_full;
        do_pop  = i_pop & ~o_empty;
        o_data  = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> src/bfpp_back.sv
// back end: six stage pipeline from frame record to clipped box and roi
`default_nettype none
module bfpp_back #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bfpp_pkg::t_cfg          i_cfg,
    input  wire                          i_rec_valid,
    input  wire signed [COORD_BITS-1:0]  i_min_x,
    input  wire signed [COORD_BITS-1:0]  i_min_y,
    input  wire signed [COORD_BITS-1:0]  i_max_x,
    input  wire signed [COORD_BITS-1:0]  i_max_y,
    input  wire                          i_bad,
    input  wire signed [COORD_BITS-1:0]  i_target_x,
    input  wire signed [COORD_BITS-1:0]  i_target_y,
    output logic                         o_rec_pop,
    input  wire                          i_pop,
    output logic                         o_empty,
    output logic                         o_box_valid,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_area_x,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_area_y,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_area_w,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_area_h,
    output logic                         o_roi_valid,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_roi_x,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_roi_y,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_roi_w,
    output logic [bfpp_pkg::DIM_BITS-1:0] o_roi_h,
    output logic signed [COORD_BITS-1:0] o_target_out_x,
    output logic signed [COORD_BITS-1:0] o_target_out_y
);
    import bfpp_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DB   = DIM_BITS;
    localparam int WW   = ((CB > DB + FRAC_BITS) ? CB : DB + FRAC_BITS) + 2;
    localparam int PW   = DB + RATIO_BITS;
    localparam int SW   = PW + 2;
    localparam int HS   = RATIO_FRAC + 1;
    localparam int RXW  = SW - HS;
    localparam int RWW  = PW + 1 - RATIO_FRAC;
    localparam int CW   = ((RXW > RWW) ? RXW : RWW) + 2;
    localparam logic [WW-1:0]   OneM1   = WW'((1 << FRAC_BITS) - 1);
    localparam logic [PW:0]     RoundUp = (PW+1)'((1 << RATIO_FRAC) - 1);

    logic en;

    // stage 1: classify frame and clip fixed point box
    logic                 r_s1_vld, r_s1_ok;
    logic [WW-1:0]        r_s1_cx0, r_s1_cx1, r_s1_cy0, r_s1_cy1;
    logic signed [CB-1:0] r_s1_tx, r_s1_ty;
    logic signed [WW-1:0] e_min_x, e_min_y, e_max_x, e_max_y, lim_x, lim_y;
    logic signed [WW-1:0] n_s1_cx0, n_s1_cx1, n_s1_cy0, n_s1_cy1;
    logic                 n_s1_ok;

    // stage 2: integer origin and size
    logic                 r_s2_vld, r_s2_ok;
    logic [WW-1:0]        r_s2_ax, r_s2_aw, r_s2_ay, r_s2_ah;
    logic signed [CB-1:0] r_s2_tx, r_s2_ty;

    // stage 3: integer area against image
    logic                 r_s3_vld, r_s3_ok;
    logic [DB-1:0]        r_s3_ax, r_s3_aw, r_s3_ay, r_s3_ah;
    logic signed [CB-1:0] r_s3_tx, r_s3_ty;
    logic [WW:0]          sx, sy, x2a, y2a, iwa, iha;
    logic                 ne_xa, ne_ya, keep_a;

    // stage 4: growth products
    logic                 r_s4_vld, r_s4_ok, r_s4_rv;
    logic [DB-1:0]        r_s4_ax, r_s4_aw, r_s4_ay, r_s4_ah;
    logic [PW-1:0]        r_s4_px, r_s4_py;
    logic signed [CB-1:0] r_s4_tx, r_s4_ty;

    // stage 5: roi edges
    logic                  r_s5_vld, r_s5_ok, r_s5_rv;
    logic [DB-1:0]         r_s5_ax, r_s5_aw, r_s5_ay, r_s5_ah;
    logic signed [RXW-1:0] r_s5_rx, r_s5_ry;
    logic [RWW-1:0]        r_s5_rw, r_s5_rh;
    logic signed [CB-1:0]  r_s5_tx, r_s5_ty;
    logic signed [SW-1:0]  dx, dy;
    logic [PW:0]           gw, gh;

    // stage 6: output register
    logic                  r_s6_vld, r_s6_ok, r_s6_rv;
    logic [DB-1:0]         r_s6_ax, r_s6_aw, r_s6_ay, r_s6_ah;
    logic [DB-1:0]         r_s6_rx, r_s6_rw, r_s6_ry, r_s6_rh;
    logic signed [CB-1:0]  r_s6_tx, r_s6_ty;
    logic signed [CW-1:0]  x1r, y1r, sxr, syr, x2r, y2r, iwr, ihr;
    logic                  ne_xr, ne_yr, keep_r;

    always_comb begin
        en        = ~r_s6_vld | i_pop;
        o_rec_pop = en & i_rec_valid;
        o_empty   = ~r_s6_vld;

        e_min_x = WW'(i_min_x);
        e_min_y = WW'(i_min_y);
        e_max_x = WW'(i_max_x);
        e_max_y = WW'(i_max_y);
        lim_x   = WW'(i_cfg.img_w) << FRAC_BITS;
        lim_y   = WW'(i_cfg.img_h) << FRAC_BITS;
        n_s1_cx0 = e_min_x[WW-1] ? '0 : e_min_x;
        n_s1_cy0 = e_min_y[WW-1] ? '0 : e_min_y;
        n_s1_cx1 = (e_max_x < lim_x) ? e_max_x : lim_x;
        n_s1_cy1 = (e_max_y < lim_y) ? e_max_y : lim_y;
        n_s1_ok  = ~i_bad & (e_max_x > e_min_x) & (e_max_y > e_min_y)
                 & (n_s1_cx1 > n_s1_cx0) & (n_s1_cy1 > n_s1_cy0);

        sx    = (WW+1)'(r_s2_ax) + (WW+1)'(r_s2_aw);
        sy    = (WW+1)'(r_s2_ay) + (WW+1)'(r_s2_ah);
        iwa   = (WW+1)'(i_cfg.img_w);
        iha   = (WW+1)'(i_cfg.img_h);
        x2a   = (sx < iwa) ? sx : iwa;
        y2a   = (sy < iha) ? sy : iha;
        ne_xa = x2a > (WW+1)'(r_s2_ax);
        ne_ya = y2a > (WW+1)'(r_s2_ay);
        keep_a = r_s2_ok & ne_xa & ne_ya;

        dx = $signed(SW'(r_s4_ax) << HS) - $signed(SW'(r_s4_px));
        dy = $signed(SW'(r_s4_ay) << HS) - $signed(SW'(r_s4_py));
        gw = ((PW+1)'(r_s4_aw) << RATIO_FRAC) + (PW+1)'(r_s4_px) + RoundUp;
        gh = ((PW+1)'(r_s4_ah) << RATIO_FRAC) + (PW+1)'(r_s4_py) + RoundUp;

        x1r = r_s5_rx[RXW-1] ? '0 : CW'(r_s5_rx);
        y1r = r_s5_ry[RXW-1] ? '0 : CW'(r_s5_ry);
        sxr = CW'(r_s5_rx) + $signed(CW'(r_s5_rw));
        syr = CW'(r_s5_ry) + $signed(CW'(r_s5_rh));
        iwr = $signed(CW'(i_cfg.img_w));
        ihr = $signed(CW'(i_cfg.img_h));
        x2r = (sxr < iwr) ? sxr : iwr;
        y2r = (syr < ihr) ? syr : ihr;
        ne_xr  = x2r > x1r;
        ne_yr  = y2r > y1r;
        keep_r = r_s5_rv & ne_xr & ne_yr;

        o_box_valid    = r_s6_ok;
        o_area_x       = r_s6_ax;
        o_area_y       = r_s6_ay;
        o_area_w       = r_s6_aw;
        o_area_h       = r_s6_ah;
        o_roi_valid    = r_s6_rv;
        o_roi_x        = r_s6_rx;
        o_roi_y        = r_s6_ry;
        o_roi_w        = r_s6_rw;
        o_roi_h        = r_s6_rh;
        o_target_out_x = r_s6_tx;
        o_target_out_y = r_s6_ty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_rec_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ok  <= n_s1_ok;
            r_s1_cx0 <= n_s1_cx0;
            r_s1_cx1 <= n_s1_cx1;
            r_s1_cy0 <= n_s1_cy0;
            r_s1_cy1 <= n_s1_cy1;
            r_s1_tx  <= i_target_x;
            r_s1_ty  <= i_target_y;

            r_s2_ok <= r_s1_ok;
            r_s2_ax <= r_s1_cx0 >> FRAC_BITS;
            r_s2_ay <= r_s1_cy0 >> FRAC_BITS;
            r_s2_aw <= (r_s1_cx1 - r_s1_cx0 + OneM1) >> FRAC_BITS;
            r_s2_ah <= (r_s1_cy1 - r_s1_cy0 + OneM1) >> FRAC_BITS;
            r_s2_tx <= r_s1_tx;
            r_s2_ty <= r_s1_ty;

            r_s3_ok <= r_s2_ok;
            r_s3_ax <= keep_a ? DB'(r_s2_ax) : '0;
            r_s3_ay <= keep_a ? DB'(r_s2_ay) : '0;
            r_s3_aw <= keep_a ? DB'(x2a - (WW+1)'(r_s2_ax)) : '0;
            r_s3_ah <= keep_a ? DB'(y2a - (WW+1)'(r_s2_ay)) : '0;
            r_s3_tx <= r_s2_tx;
            r_s3_ty <= r_s2_ty;

            r_s4_ok <= r_s3_ok;
            r_s4_rv <= r_s3_ok & i_cfg.roi_enable & (r_s3_aw != '0) & (r_s3_ah != '0);
            r_s4_ax <= r_s3_ax;
            r_s4_ay <= r_s3_ay;
            r_s4_aw <= r_s3_aw;
            r_s4_ah <= r_s3_ah;
            r_s4_px <= PW'(r_s3_aw) * PW'(i_cfg.grow_ratio);
            r_s4_py <= PW'(r_s3_ah) * PW'(i_cfg.grow_ratio);
            r_s4_tx <= r_s3_tx;
            r_s4_ty <= r_s3_ty;

            r_s5_ok <= r_s4_ok;
            r_s5_rv <= r_s4_rv;
            r_s5_ax <= r_s4_ax;
            r_s5_ay <= r_s4_ay;
            r_s5_aw <= r_s4_aw;
            r_s5_ah <= r_s4_ah;
            r_s5_rx <= RXW'(dx >>> HS);
            r_s5_ry <= RXW'(dy >>> HS);
            r_s5_rw <= RWW'(gw >> RATIO_FRAC);
            r_s5_rh <= RWW'(gh >> RATIO_FRAC);
            r_s5_tx <= r_s4_tx;
            r_s5_ty <= r_s4_ty;

            r_s6_ok <= r_s5_ok;
            r_s6_rv <= r_s5_rv;
            r_s6_ax <= r_s5_ax;
            r_s6_ay <= r_s5_ay;
            r_s6_aw <= r_s5_aw;
            r_s6_ah <= r_s5_ah;
            r_s6_rx <= keep_r ? DB'(x1r) : '0;
            r_s6_ry <= keep_r ? DB'(y1r) : '0;
            r_s6_rw <= keep_r ? DB'(x2r - x1r) : '0;
            r_s6_rh <= keep_r ? DB'(y2r - y1r) : '0;
            r_s6_tx <= r_s5_ok ? r_s5_tx : '0;
            r_s6_ty <= r_s5_ok ? r_s5_ty : '0;
        end
    end

endmodule
`default_nettype wire

>>> src/bbox_from_projected_points_top.sv
// top level: config registers, point accumulator, frame queue and box pipeline
//
// Takes one projected point per clock while full is low; full rises only while
// the four-entry frame queue is full, which happens when results are not being
// popped. The item flagged last closes the frame and yields one result via the
// frame queue and five pipeline stages plus the output register (these stall
// together while it holds an unpopped result). Back-to-back single-point frames
// also run at one item per cycle while full is low. Configuration writes are
// always ready and take effect the next cycle; write them only while idle.
`default_nettype none
module bbox_from_projected_points_top #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [bfpp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire [bfpp_pkg::DIM_BITS-1:0]          i_cfg_data,
    input  wire                                   push,
    output logic                                  full,
    input  wire signed [COORD_BITS-1:0]           i_point_x,
    input  wire signed [COORD_BITS-1:0]           i_point_y,
    input  wire                                   i_point_ok,
    input  wire signed [COORD_BITS-1:0]           i_target_x,
    input  wire signed [COORD_BITS-1:0]           i_target_y,
    input  wire                                   i_last_point,
    output logic                                  empty,
    input  wire                                   pop,
    output logic                                  o_box_valid,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_area_x,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_area_y,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_area_w,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_area_h,
    output logic                                  o_roi_valid,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_roi_x,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_roi_y,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_roi_w,
    output logic [bfpp_pkg::DIM_BITS-1:0]         o_roi_h,
    output logic signed [COORD_BITS-1:0]          o_target_out_x,
    output logic signed [COORD_BITS-1:0]          o_target_out_y
);
    import bfpp_pkg::*;

    localparam int RecW = 6 * COORD_BITS + 1;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic                         accept;
    logic                         rec_push;
    logic signed [COORD_BITS-1:0] f_min_x, f_min_y, f_max_x, f_max_y;
    logic                         f_bad;
    logic [RecW-1:0]              q_in, q_out;
    logic                         q_full, q_empty, q_pop;
    logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_max_x, b_max_y;
    logic signed [COORD_BITS-1:0] b_tx, b_ty;
    logic                         b_bad;

    always_comb begin
        o_cfg_ready = 1'b1;
        n_cfg       = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_W:      n_cfg.img_w      = i_cfg_data;
                CFG_IMG_H:      n_cfg.img_h      = i_cfg_data;
                CFG_ROI_ENABLE: n_cfg.roi_enable = i_cfg_data[0];
                CFG_GROW_RATIO: n_cfg.grow_ratio = i_cfg_data[RATIO_BITS-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_w      <= RST_IMG_W;
            r_cfg.img_h      <= RST_IMG_H;
            r_cfg.roi_enable <= RST_ROI_ENABLE;
            r_cfg.grow_ratio <= RST_GROW_RATIO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign full   = q_full;
    assign accept = push & ~q_full;

    bfpp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_ok   (i_point_ok),
        .i_last_point (i_last_point),
        .o_rec_push   (rec_push),
        .o_min_x      (f_min_x),
        .o_min_y      (f_min_y),
        .o_max_x      (f_max_x),
        .o_max_y      (f_max_y),
        .o_bad        (f_bad)
    );

    assign q_in = {f_min_x, f_min_y, f_max_x, f_max_y, f_bad, i_target_x, i_target_y};

    bfpp_fifo #(
        .WIDTH (RecW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign {b_min_x, b_min_y, b_max_x, b_max_y, b_bad, b_tx, b_ty} = q_out;

    bfpp_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_rec_valid    (~q_empty),
        .i_min_x        (b_min_x),
        .i_min_y        (b_min_y),
        .i_max_x        (b_max_x),
        .i_max_y        (b_max_y),
        .i_bad          (b_bad),
        .i_target_x     (b_tx),
        .i_target_y     (b_ty),
        .o_rec_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_box_valid    (o_box_valid),
        .o_area_x       (o_area_x),
        .o_area_y       (o_area_y),
        .o_area_w       (o_area_w),
        .o_area_h       (o_area_h),
        .o_roi_valid    (o_roi_valid),
        .o_roi_x        (o_roi_x),
        .o_roi_y        (o_roi_y),
        .o_roi_w        (o_roi_w),
        .o_roi_h        (o_roi_h),
        .o_target_out_x (o_target_out_x),
        .o_target_out_y (o_target_out_y)
    );

endmodule
`default_nettype wire
